// ===== rtl/pcpg_pkg.sv =====
// Package for the plain-changes permutation generator.
// Holds widths, the cell control and link types and the identity order word.
// No dependencies.
`default_nettype none

package pcpg_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int ELEM_W       = 4;
    localparam int CNT_W        = 5;
    localparam int Q_W          = CNT_W + 1;
    localparam int K_W          = IDX_W;
    localparam int POS_W        = Q_W;
    localparam int SIZE_W       = 5;
    localparam int WORD_W       = 64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

    // broadcast from the top level to every cell
    typedef struct packed {
        logic              load_id;
        logic              advance;
        logic              do_swap;
        logic [IDX_W-1:0]  swap_pos;
    } pcpg_cell_ctl_t;

    // handed from cell m+1 down to cell m
    typedef struct packed {
        logic              carry;
        logic [K_W-1:0]    k;
    } pcpg_link_t;

    // identity permutation packed one nibble per entry
    function automatic logic [WORD_W-1:0] identity_word();
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            w[ELEM_W*i +: ELEM_W] = ELEM_W'(i);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pcpg_cell.sv =====
// One level cell of the plain-changes generator: order entry, counter, direction.
// Depends on pcpg_pkg.
`default_nettype none

module pcpg_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pcpg_pkg::pcpg_cell_ctl_t      ctl,
    input  wire logic [pcpg_pkg::IDX_W-1:0]    cell_idx,
    input  wire pcpg_pkg::pcpg_link_t          link_in,
    output pcpg_pkg::pcpg_link_t               link_out,
    input  wire logic [pcpg_pkg::ELEM_W-1:0]   order_left,
    input  wire logic [pcpg_pkg::ELEM_W-1:0]   order_right,
    output logic [pcpg_pkg::ELEM_W-1:0]        order_q,
    output logic                               hit,
    output logic [pcpg_pkg::POS_W-1:0]         hit_pos
);
    import pcpg_pkg::*;

    logic [ELEM_W-1:0] order_reg, order_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              down_reg, down_next;
    logic [Q_W-1:0]    q;
    logic              bounce_top;
    logic              bounce_zero;
    logic              done;
    logic              active;

    // next counter value and bounce detection
    always_comb begin
        if (down_reg) begin
            q = (count_reg == '0) ? '0 : Q_W'(count_reg) - Q_W'(1);
        end else begin
            q = Q_W'(count_reg) + Q_W'(1);
        end
        bounce_top  = (q == Q_W'(cell_idx) + Q_W'(1));
        bounce_zero = (q == '0);
        done        = !bounce_top && !bounce_zero;
    end

    // scan chain toward the lower level
    assign active         = link_in.carry && ctl.advance;
    assign link_out.carry = link_in.carry && !done;
    assign link_out.k     = link_in.k + K_W'(link_in.carry && bounce_zero);
    assign hit            = link_in.carry && done;
    assign hit_pos        = q + POS_W'(link_in.k);

    // counter and direction update
    always_comb begin
        count_next = count_reg;
        down_next  = down_reg;
        if (ctl.load_id) begin
            count_next = '0;
            down_next  = 1'b0;
        end else if (active) begin
            count_next = q[CNT_W-1:0];
            if (bounce_top) begin
                down_next = 1'b1;
            end else if (bounce_zero) begin
                down_next = 1'b0;
            end
        end
    end

    // order entry: identity load or adjacent swap with a neighbor
    always_comb begin
        order_next = order_reg;
        if (ctl.load_id) begin
            order_next = ELEM_W'(cell_idx);
        end else if (ctl.do_swap) begin
            if (cell_idx == ctl.swap_pos - IDX_W'(1)) begin
                order_next = order_right;
            end else if (cell_idx == ctl.swap_pos) begin
                order_next = order_left;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ELEM_W'(cell_idx);
            count_reg <= '0;
            down_reg  <= 1'b0;
        end else begin
            order_reg <= order_next;
            count_reg <= count_next;
            down_reg  <= down_next;
        end
    end

    assign order_q = order_reg;

endmodule

`default_nettype wire

// ===== rtl/plain_changes_permutation_gen_core.sv =====
// Plain-changes permutation generator, top level: size register, cell row, result stage.
// Depends on pcpg_pkg and pcpg_cell.
//
// Usage:
//   Configuration: cfg_wr_en with cfg_wr_data writes the size (0 acts as 1,
//   above 16 acts as 16). Write it only while no request is outstanding.
//   Input channel (s_valid/s_ready/s_restart): one request per permutation.
//   s_restart = 1 loads the identity order and returns it; s_restart = 0
//   steps to the next order by one adjacent swap.
//   Result channel (m_valid/m_ready): m_found, m_order_word (entry i in bits
//   4i+3..4i) and m_swap_position (upper index of the swapped pair).
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while the result stage is not stalled;
//   the level scan ripples combinationally through the row of sixteen cells,
//   and the cell registers update at acceptance.
//   Stall: while a result waits with m_ready low, s_ready is low and the
//   generator state holds; s_ready returns high in the cycle the result is
//   taken, so a new request can be accepted in that same cycle.
//   Reset: synchronous active-low aresetn loads the identity order, clears
//   counters and directions, clears the exhausted flag, sets the size to 4
//   and empties the result stage.
//   Once every permutation has been produced, m_found is 0 and the order
//   holds until the next restart request.
`default_nettype none

module plain_changes_permutation_gen_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [pcpg_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_restart,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_found,
    output logic [pcpg_pkg::WORD_W-1:0]         m_order_word,
    output logic [pcpg_pkg::IDX_W-1:0]          m_swap_position
);
    import pcpg_pkg::*;

    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  size_eff;
    logic [IDX_W-1:0]   top_idx;
    logic               exhausted_reg, exhausted_next;
    logic               m_valid_reg, m_valid_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   swap_pos_reg, swap_pos_next;
    logic               accept;
    logic               exhausting;
    logic               any_hit;
    logic [POS_W-1:0]   pos;
    logic               pos_ok;
    pcpg_cell_ctl_t     ctl;

    pcpg_link_t                  link_in  [MAX_ELEMENTS];
    pcpg_link_t                  link_out [MAX_ELEMENTS];
    logic [ELEM_W-1:0]           order_q  [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]     hit;
    logic [POS_W-1:0]            hit_pos  [MAX_ELEMENTS];

    // size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    // clamp size into 1..MAX_ELEMENTS
    always_comb begin
        if (size_reg == '0) begin
            size_eff = SIZE_W'(1);
        end else if (size_reg > SIZE_W'(MAX_ELEMENTS)) begin
            size_eff = SIZE_W'(MAX_ELEMENTS);
        end else begin
            size_eff = size_reg;
        end
    end
    assign top_idx = IDX_W'(size_eff - SIZE_W'(1));

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // scan entry: the chain starts at the top level, cells above it stay idle
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_link
        if (g == MAX_ELEMENTS - 1) begin : g_last
            assign link_in[g].carry = (top_idx == IDX_W'(g));
            assign link_in[g].k     = '0;
        end else begin : g_mid
            always_comb begin
                if (top_idx == IDX_W'(g)) begin
                    link_in[g].carry = 1'b1;
                    link_in[g].k     = '0;
                end else if (top_idx > IDX_W'(g) && g != 0) begin
                    link_in[g] = link_out[g+1];
                end else begin
                    link_in[g].carry = 1'b0;
                    link_in[g].k     = '0;
                end
            end
        end
    end

    // cell row
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic [ELEM_W-1:0] left_v;
        logic [ELEM_W-1:0] right_v;
        if (g == 0) begin : g_lo
            assign left_v = '0;
        end else begin : g_lo_n
            assign left_v = order_q[g-1];
        end
        if (g == MAX_ELEMENTS - 1) begin : g_hi
            assign right_v = '0;
        end else begin : g_hi_n
            assign right_v = order_q[g+1];
        end

        pcpg_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .cell_idx    (IDX_W'(g)),
            .link_in     (link_in[g]),
            .link_out    (link_out[g]),
            .order_left  (left_v),
            .order_right (right_v),
            .order_q     (order_q[g]),
            .hit         (hit[g]),
            .hit_pos     (hit_pos[g])
        );

        assign m_order_word[ELEM_W*g +: ELEM_W] = order_q[g];
    end
    if (WORD_W > ELEM_W * MAX_ELEMENTS) begin : g_pad
        assign m_order_word[WORD_W-1:ELEM_W*MAX_ELEMENTS] = '0;
    end

    // the lowest scanned level runs off the end: all orders produced
    assign exhausting = (top_idx == '0) ? link_out[0].carry : link_out[1].carry;

    // select the swap position of the level that stopped the scan
    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            pos = pos | (hit[i] ? hit_pos[i] : '0);
        end
        any_hit = |hit;
        pos_ok  = any_hit && (pos >= POS_W'(1)) && (pos < POS_W'(size_eff));
    end

    // cell control
    always_comb begin
        ctl.load_id  = accept && s_restart;
        ctl.advance  = accept && !s_restart && !exhausted_reg;
        ctl.do_swap  = ctl.advance && pos_ok;
        ctl.swap_pos = pos[IDX_W-1:0];
    end

    // result and exhausted flag
    always_comb begin
        exhausted_next = exhausted_reg;
        found_next     = found_reg;
        swap_pos_next  = swap_pos_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            if (s_restart) begin
                exhausted_next = 1'b0;
                found_next     = 1'b1;
                swap_pos_next  = '0;
            end else if (exhausted_reg) begin
                found_next    = 1'b0;
                swap_pos_next = '0;
            end else if (exhausting) begin
                exhausted_next = 1'b1;
                found_next     = 1'b0;
                swap_pos_next  = '0;
            end else begin
                found_next    = 1'b1;
                swap_pos_next = pos_ok ? pos[IDX_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exhausted_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            exhausted_reg <= exhausted_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg    <= found_next;
        swap_pos_reg <= swap_pos_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = found_reg;
    assign m_swap_position = swap_pos_reg;

    // at most one level stops the scan
    a_hit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit))
        else $error("more than one cell stopped the level scan");

    // a swap never coincides with exhaustion
    a_swap_not_exh: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.do_swap |-> !exhausting)
        else $error("swap issued on an exhausting step");

    // restart returns the identity order
    a_restart_id: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_restart |=> m_order_word == identity_word() && m_found)
        else $error("restart did not return the identity order");

    // once exhausted, a step leaves the order alone
    a_exh_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_restart && exhausted_reg |=> $stable(m_order_word) && !m_found)
        else $error("order changed while exhausted");

    // no swap position without a new permutation
    a_pos_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_swap_position == '0)
        else $error("swap position reported without a permutation");

endmodule

`default_nettype wire
